/* sv/mixed_rational_alu_macros.svh */
// mixed_rational_alu_macros.svh: assertion macros for the rational alu checker
// no dependencies
`ifndef MIXED_RATIONAL_ALU_MACROS_SVH
`define MIXED_RATIONAL_ALU_MACROS_SVH
// property must hold at every edge outside reset
`define MRA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked during reset as well
`define MRA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* sv/mra_pkg.sv */
// mra_pkg: types, codes and widths shared by the rational alu modules
// no dependencies
package mra_pkg;
    localparam int unsigned QueueDepth = 2;

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_MUL = 2'd2;
    localparam logic [1:0] ACT_DIV = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    // classified transaction handed from front to back
    typedef struct packed {
        logic [1:0]  status;
        logic        neg;
        logic [31:0] nmag;
        logic [31:0] dmag;
    } t_job;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] res_whole;
        logic [31:0] res_num;
        logic [30:0] res_den;
    } t_res;
endpackage

/* sv/mra_front.sv */
// mra_front: accepts operands, builds improper fractions, cross-multiplies
// depends on mra_pkg
module mra_front import mra_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_lhs_whole,
    input  logic [31:0] i_lhs_num,
    input  logic [31:0] i_lhs_den,
    input  logic [31:0] i_rhs_whole,
    input  logic [31:0] i_rhs_num,
    input  logic [31:0] i_rhs_den,
    output logic        o_job_valid,
    input  logic        i_job_stall,
    output t_job        o_job
);
    // sequencer: load, improper products, cross products, sum, emit
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_IMP1 = 3'd1;
    localparam logic [2:0] S_IMP2 = 3'd2;
    localparam logic [2:0] S_X1   = 3'd3;
    localparam logic [2:0] S_X2   = 3'd4;
    localparam logic [2:0] S_X3   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]  r_state, n_state;
    logic [1:0]  r_act;
    logic [31:0] r_w1, r_n1, r_d1, r_w2, r_n2, r_d2;
    logic [31:0] r_p1, r_p2, r_a, r_b, r_c;
    logic        r_p2z;
    t_job        r_job;

    function automatic logic [31:0] mag(input logic [31:0] x);
        mag = x[31] ? 32'(-x) : x;
    endfunction

    // improper numerator modulo 2^32 (only low bits matter after wrap)
    function automatic logic [31:0] imp(input logic [31:0] w, input logic [31:0] n,
                                        input logic [31:0] d);
        logic        neg;
        logic [31:0] t;
        neg = w[31] || (w == '0 && n[31]);
        t   = 32'(mag(w) * d) + mag(n);
        imp = neg ? 32'(-t) : t;
    endfunction

    // exact zero test of the improper numerator, wrapped bits do not count
    function automatic logic imp_zero(input logic [31:0] w, input logic [31:0] n,
                                      input logic [31:0] d);
        logic [63:0] prod;
        prod     = {32'd0, mag(w)} * {32'd0, mag(d)};
        imp_zero = (w == '0) ? (n == '0) : (d[31] && prod == {32'd0, mag(n)});
    endfunction

    logic [31:0] w_n, w_d;
    logic        w_zero_den;
    assign w_zero_den = (r_d1 == '0) || (r_d2 == '0);

    always_comb begin
        w_n = r_a;
        w_d = r_c;
        case (r_act)
            ACT_ADD: w_n = r_a + r_b;
            ACT_SUB: w_n = r_a - r_b;
            default: w_n = r_a;
        endcase
        if (w_d[31]) begin
            w_n = 32'(-w_n);
            w_d = 32'(-w_d);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_IMP1;
            S_IMP1:  n_state = S_IMP2;
            S_IMP2:  n_state = S_X1;
            S_X1:    n_state = S_X2;
            S_X2:    n_state = S_X3;
            S_X3:    n_state = S_FIN;
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (!i_job_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_act <= i_action;
                r_w1 <= i_lhs_whole; r_n1 <= i_lhs_num; r_d1 <= i_lhs_den;
                r_w2 <= i_rhs_whole; r_n2 <= i_rhs_num; r_d2 <= i_rhs_den;
            end
            S_IMP1:  r_p1 <= imp(r_w1, r_n1, r_d1);
            S_IMP2: begin
                r_p2  <= imp(r_w2, r_n2, r_d2);
                r_p2z <= imp_zero(r_w2, r_n2, r_d2);
            end
            S_X1:    r_a <= (r_act == ACT_MUL) ? 32'(r_p1 * r_p2) : 32'(r_p1 * r_d2);
            S_X2:    r_b <= 32'(r_p2 * r_d1);
            S_X3:    r_c <= (r_act == ACT_DIV) ? 32'(r_d1 * r_p2) : 32'(r_d1 * r_d2);
            S_FIN: begin
                r_job.neg  <= w_n[31];
                r_job.nmag <= mag(w_n);
                r_job.dmag <= w_d;
                if (w_zero_den) begin
                    r_job.status <= ST_ZERO_DEN;
                end else if (r_act == ACT_DIV && r_p2z) begin
                    r_job.status <= ST_DIV_ZERO;
                end else begin
                    r_job.status <= ST_OK;
                end
            end
            default: ;
        endcase
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_job_valid = (r_state == S_OUT);
    assign o_job       = r_job;
endmodule

/* sv/mra_queue.sv */
// mra_queue: short fifo between classifier and reduction engine
// depends on mra_pkg
module mra_queue import mra_pkg::*; #(
    parameter int unsigned Depth = QueueDepth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_stall,
    output t_job o_job
);
    localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
    t_job           r_mem [Depth];
    logic [Aw-1:0]  r_wp, r_rp;
    logic [Aw:0]    r_cnt;
    logic           w_push, w_pop;

    assign o_stall = (r_cnt == (Aw+1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;
    assign o_job   = r_mem[r_rp];

    function automatic logic [Aw-1:0] inc(input logic [Aw-1:0] p);
        inc = (p == Aw'(Depth - 1)) ? '0 : Aw'(p + 1'b1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= inc(r_wp);
            if (w_pop) r_rp <= inc(r_rp);
            r_cnt <= r_cnt + (Aw+1)'(w_push) - (Aw+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_job;
    end
endmodule

/* sv/mra_back.sv */
// mra_back: euclidean gcd, reduction and mixed-number split, one bit per cycle divider
// depends on mra_pkg
module mra_back import mra_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_job        i_job,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_res_whole,
    output logic [31:0] o_res_num,
    output logic [30:0] o_res_den
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DQ   = 3'd2;
    localparam logic [2:0] S_DD   = 3'd3;
    localparam logic [2:0] S_DW   = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]  r_state, n_state, r_ret;
    logic        r_neg, r_ovalid;
    logic [31:0] r_n, r_d, r_a, r_b, r_g, r_q, r_dd;
    // shared restoring divider
    logic [31:0] r_dvd, r_dvs, r_quo;
    logic [32:0] r_rem;
    logic [4:0]  r_bit;
    t_res        r_res;
    logic [32:0] w_trial;
    logic        w_short;

    assign w_trial = {r_rem[31:0], r_dvd[r_bit]} - {1'b0, r_dvs};
    // errors, zero fractions and zero denominators skip the engine
    assign w_short = (i_job.status != ST_OK) || (i_job.nmag == '0) || (i_job.dmag == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid && !r_ovalid && !w_short) n_state = S_GCD;
            S_GCD:   if (r_b == '0) n_state = S_DQ; else n_state = S_DIV;
            S_DQ:    n_state = S_DIV;
            S_DD:    n_state = S_DIV;
            S_DW:    n_state = S_DIV;
            S_DIV:   if (r_bit == '0) n_state = r_ret;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (r_state == S_DONE) r_ovalid <= 1'b1;
            if (r_state == S_IDLE && i_valid && !r_ovalid && w_short)
                r_ovalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // keep the waiting result intact
                if (!r_ovalid) begin
                    r_neg <= i_job.neg;
                    r_n <= i_job.nmag; r_d <= i_job.dmag;
                    r_a <= i_job.nmag; r_b <= i_job.dmag;
                    r_res.status <= i_job.status;
                    r_res.res_whole <= '0; r_res.res_num <= '0; r_res.res_den <= 31'd1;
                end
            end
            S_GCD: begin
                if (r_b == '0) begin
                    r_g <= r_a;
                end else begin
                    r_dvd <= r_a; r_dvs <= r_b; r_rem <= '0; r_quo <= '0;
                    r_bit <= 5'd31; r_ret <= S_GCD;
                end
            end
            S_DQ: begin
                r_dvd <= r_n; r_dvs <= r_g; r_rem <= '0; r_quo <= '0;
                r_bit <= 5'd31; r_ret <= S_DD;
            end
            S_DD: begin
                r_q <= r_quo;
                r_dvd <= r_d; r_dvs <= r_g; r_rem <= '0; r_quo <= '0;
                r_bit <= 5'd31; r_ret <= S_DW;
            end
            S_DW: begin
                r_dd <= r_quo;
                r_dvd <= r_q; r_dvs <= r_quo; r_rem <= '0; r_quo <= '0;
                r_bit <= 5'd31; r_ret <= S_DONE;
            end
            S_DIV: begin
                if (!w_trial[32]) begin
                    r_rem <= w_trial;
                    r_quo[r_bit] <= 1'b1;
                end else begin
                    r_rem <= {r_rem[31:0], r_dvd[r_bit]};
                end
                r_bit <= r_bit - 5'd1;
                // gcd step: a <= b, b <= a mod b once the division ends
                if (r_bit == '0 && r_ret == S_GCD) begin
                    r_a <= r_b;
                    r_b <= !w_trial[32] ? w_trial[31:0] : {r_rem[30:0], r_dvd[0]};
                end
            end
            S_DONE: begin
                if (!r_neg) begin
                    r_res.res_whole <= r_quo;
                    r_res.res_num   <= r_rem[31:0];
                end else if (r_quo == '0) begin
                    r_res.res_whole <= '0;
                    r_res.res_num   <= 32'(-r_rem[31:0]);
                end else begin
                    r_res.res_whole <= 32'(-r_quo);
                    r_res.res_num   <= r_rem[31:0];
                end
                r_res.res_den <= (r_rem == '0) ? 31'd1 : r_dd[30:0];
            end
            default: ;
        endcase
    end

    assign o_stall     = (r_state != S_IDLE) || r_ovalid;
    assign o_valid     = r_ovalid;
    assign o_status    = r_res.status;
    assign o_res_whole = r_res.res_whole;
    assign o_res_num   = r_res.res_num;
    assign o_res_den   = r_res.res_den;
endmodule

/* sv/mixed_rational_alu.sv */
// mixed_rational_alu: top level, front classifier, queue and reduction engine
// depends on mra_pkg, mra_front, mra_queue, mra_back
//
// channel  direction  handshake          payload
// in       input      i_valid/o_stall    action, lhs_*, rhs_*
// out      output     o_valid/i_stall    status, res_whole, res_num, res_den
//
// front works on one transaction at a time (32x32 multiplies spread over its sequencer steps)
// back runs its divider for 1 to about 46 gcd passes plus three divisions;
// errors and zero results skip the engine and are ready in the cycle after being taken
// synchronous active-low reset clears control only; queue holds QDepth jobs, two by default
// output result holds while i_stall is high; back stops taking jobs until it leaves
module mixed_rational_alu import mra_pkg::*; #(
    parameter int unsigned QDepth = QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_lhs_whole,
    input  logic [31:0] i_lhs_num,
    input  logic [31:0] i_lhs_den,
    input  logic [31:0] i_rhs_whole,
    input  logic [31:0] i_rhs_num,
    input  logic [31:0] i_rhs_den,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_res_whole,
    output logic [31:0] o_res_num,
    output logic [30:0] o_res_den
);
    t_job w_fjob, w_qjob;
    logic w_fvalid, w_fstall, w_qvalid, w_qstall;

    mra_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_action, .i_lhs_whole, .i_lhs_num, .i_lhs_den,
        .i_rhs_whole, .i_rhs_num, .i_rhs_den,
        .o_job_valid(w_fvalid), .i_job_stall(w_fstall), .o_job(w_fjob)
    );

    mra_queue #(.Depth(QDepth)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_fvalid), .o_stall(w_fstall), .i_job(w_fjob),
        .o_valid(w_qvalid), .i_stall(w_qstall), .o_job(w_qjob)
    );

    mra_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_qvalid), .o_stall(w_qstall), .i_job(w_qjob),
        .o_valid, .i_stall, .o_status, .o_res_whole, .o_res_num, .o_res_den
    );
endmodule

/* sv/mra_checker.sv */
// mra_checker: port-level checks on the rational alu, bound to the top level
// depends on mra_pkg and mixed_rational_alu_macros.svh
`include "mixed_rational_alu_macros.svh"
module mra_checker import mra_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [31:0] o_res_whole,
    input logic [31:0] o_res_num,
    input logic [30:0] o_res_den
);
    `MRA_ASSERT(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_res_num), "result dropped")
    `MRA_ASSERT(a_err_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK |-> o_res_whole == '0 && o_res_num == '0 && o_res_den == 31'd1, "error not cleared")
    `MRA_ASSERT(a_status, i_clk, i_rst_n, o_valid |-> o_status <= ST_DIV_ZERO, "bad status")
    `MRA_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
endmodule

bind mixed_rational_alu mra_checker u_checker (.*);
